@@ design/pse_pkg.sv @@
`timescale 1ns / 1ps

package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;

  localparam int IDX_W     = $clog2(STACK_DEPTH);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_OP   = 2'd1;
  localparam logic [1:0] REQ_END  = 2'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_OP = 3'd3;
  localparam logic [2:0] ST_LEFTOVER   = 3'd4;
  localparam logic [2:0] ST_SATURATED  = 3'd5;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
    logic [2:0]         op_code;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] answer;
    logic               expr_done;
  } out_t;

  typedef struct packed {
    logic cap;
    logic addsub;
    logic mul;
    logic mul_fix;
    logic div_init;
    logic div_step;
    logic div_fix;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic cnt_lt2;
    logic div_zero;
    logic div_last;
  } stat_t;

endpackage

@@ design/pse_ctrl.sv @@
`timescale 1ns / 1ps

module pse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_req_type,
  input  logic [2:0]     in_op_code,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pse_pkg::stat_t stat,
  output pse_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDSUB,
    S_MUL,
    S_MULFIX,
    S_DIVINIT,
    S_DIVRUN,
    S_DIVFIX,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   op_known;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign op_known  = in_op_code inside {pse_pkg::OP_ADD, pse_pkg::OP_SUB,
                                        pse_pkg::OP_MUL, pse_pkg::OP_DIV};

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          case (in_req_type)
            pse_pkg::REQ_PUSH, pse_pkg::REQ_END: state_nxt = S_FIN;
            pse_pkg::REQ_OP: begin
              if (!op_known || stat.cnt_lt2) begin
                state_nxt = S_FIN;
              end else begin
                case (in_op_code)
                  pse_pkg::OP_ADD, pse_pkg::OP_SUB: state_nxt = S_ADDSUB;
                  pse_pkg::OP_MUL:                  state_nxt = S_MUL;
                  default:                          state_nxt = S_DIVINIT;
                endcase
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADDSUB: begin
        cmd.addsub = 1'b1;
        state_nxt  = S_FIN;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MULFIX;
      end
      S_MULFIX: begin
        cmd.mul_fix = 1'b1;
        state_nxt   = S_FIN;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = stat.div_zero ? S_FIN : S_DIVRUN;
      end
      S_DIVRUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DIVFIX;
        end
      end
      S_DIVFIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ready) |=> (state_r == S_FIN))
    else $error("result committed over a pending transfer");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVRUN && !stat.div_last) |=> (state_r == S_DIVRUN))
    else $error("divide left early");

endmodule

@@ design/pse_datapath.sv @@
`timescale 1ns / 1ps

module pse_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  pse_pkg::in_t   in_data,
  input  pse_pkg::cmd_t  cmd,
  output pse_pkg::stat_t stat,
  output pse_pkg::out_t  out_data
);

  localparam int IDX_W     = pse_pkg::IDX_W;
  localparam int CNT_W     = pse_pkg::CNT_W;
  localparam int DIV_W     = pse_pkg::DIV_W;
  localparam int DIV_CNT_W = pse_pkg::DIV_CNT_W;

  logic [31:0]        stack_mem [pse_pkg::STACK_DEPTH];
  logic signed [31:0] rd_a_r, rd_b_r;
  pse_pkg::in_t       tok_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [2:0]         err_r, err_nxt;
  logic signed [31:0] res_r;
  logic               sat_r;
  logic signed [63:0] prod_r;
  pse_pkg::out_t      out_r;

  logic [DIV_W-1:0]     dvd_r;
  logic [31:0]          dvs_r, rem_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [CNT_W-1:0]   cnt_m1, cnt_m2;
  logic               full;
  logic               op_known;
  logic signed [32:0] sum;
  logic signed [63:0] sh;
  logic [31:0]        a_mag, b_mag;
  logic [32:0]        shifted, diff;
  logic               ge;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [31:0]        wr_data;
  logic [2:0]         code, status;
  logic signed [31:0] ans;
  logic               done;

  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_m2   = cnt_r - CNT_W'(2);
  assign full     = (cnt_r == CNT_W'(pse_pkg::STACK_DEPTH));
  assign op_known = tok_r.op_code inside {pse_pkg::OP_ADD, pse_pkg::OP_SUB,
                                          pse_pkg::OP_MUL, pse_pkg::OP_DIV};

  assign stat.cnt_lt2  = (cnt_r < CNT_W'(2));
  assign stat.div_zero = (rd_a_r == 32'sd0);
  assign stat.div_last = (div_cnt_r == DIV_CNT_W'(1));

  assign sum = (tok_r.op_code == pse_pkg::OP_SUB) ?
               ({rd_b_r[31], rd_b_r} - {rd_a_r[31], rd_a_r}) :
               ({rd_b_r[31], rd_b_r} + {rd_a_r[31], rd_a_r});
  assign sh  = prod_r >>> pse_pkg::FRAC_BITS;

  assign a_mag = rd_b_r[31] ? (~rd_b_r + 32'd1) : rd_b_r;
  assign b_mag = rd_a_r[31] ? (~rd_a_r + 32'd1) : rd_a_r;

  assign shifted = {rem_r, dvd_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_comb begin
    code    = pse_pkg::ST_OK;
    ans     = 32'sd0;
    wr_en   = 1'b0;
    wr_idx  = cnt_r[IDX_W-1:0];
    wr_data = tok_r.value;
    cnt_nxt = cnt_r;
    done    = 1'b0;
    case (tok_r.req_type)
      pse_pkg::REQ_PUSH: begin
        ans = tok_r.value;
        if (full) begin
          code = pse_pkg::ST_OVERFLOW;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      pse_pkg::REQ_OP: begin
        if (!op_known) begin
          code = pse_pkg::ST_UNKNOWN_OP;
        end else if (stat.cnt_lt2) begin
          code = pse_pkg::ST_UNDERFLOW;
        end else begin
          ans     = res_r;
          wr_en   = 1'b1;
          wr_idx  = cnt_m2[IDX_W-1:0];
          wr_data = res_r;
          cnt_nxt = cnt_m1;
          if (sat_r) begin
            code = pse_pkg::ST_SATURATED;
          end
        end
      end
      pse_pkg::REQ_END: begin
        done    = 1'b1;
        cnt_nxt = '0;
        if (cnt_r == '0) begin
          code = pse_pkg::ST_UNDERFLOW;
        end else begin
          ans = rd_a_r;
          if (cnt_r > CNT_W'(1)) begin
            code = pse_pkg::ST_LEFTOVER;
          end
        end
      end
      default: ;
    endcase
    status  = (err_r != pse_pkg::ST_OK) ? err_r : code;
    err_nxt = done ? pse_pkg::ST_OK : status;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      stack_mem[wr_idx] <= wr_data;
    end
    rd_a_r <= stack_mem[cnt_m1[IDX_W-1:0]];
    rd_b_r <= stack_mem[cnt_m2[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      err_r <= pse_pkg::ST_OK;
    end else if (cmd.commit) begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      tok_r <= in_data;
    end
    if (cmd.commit) begin
      out_r.status    <= status;
      out_r.answer    <= ans;
      out_r.expr_done <= done;
    end
    if (cmd.addsub) begin
      sat_r <= (sum[32] != sum[31]);
      res_r <= (sum[32] != sum[31]) ? (sum[32] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX)
                                    : sum[31:0];
    end
    if (cmd.mul) begin
      prod_r <= rd_b_r * rd_a_r;
    end
    if (cmd.mul_fix) begin
      if (sh > 64'(pse_pkg::Q_MAX)) begin
        sat_r <= 1'b1;
        res_r <= pse_pkg::Q_MAX;
      end else if (sh < 64'(pse_pkg::Q_MIN)) begin
        sat_r <= 1'b1;
        res_r <= pse_pkg::Q_MIN;
      end else begin
        sat_r <= 1'b0;
        res_r <= sh[31:0];
      end
    end
    if (cmd.div_init) begin
      dvd_r     <= DIV_W'(a_mag) << pse_pkg::FRAC_BITS;
      dvs_r     <= b_mag;
      rem_r     <= '0;
      neg_r     <= rd_b_r[31] ^ rd_a_r[31];
      div_cnt_r <= DIV_CNT_W'(DIV_W);
      sat_r     <= 1'b1;
      res_r     <= rd_b_r[31] ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
    end
    if (cmd.div_step) begin
      rem_r     <= ge ? diff[31:0] : shifted[31:0];
      dvd_r     <= {dvd_r[DIV_W-2:0], ge};
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
    if (cmd.div_fix) begin
      if (!neg_r && dvd_r > DIV_W'(32'h7FFF_FFFF)) begin
        sat_r <= 1'b1;
        res_r <= pse_pkg::Q_MAX;
      end else if (neg_r && dvd_r > DIV_W'(33'h0_8000_0000)) begin
        sat_r <= 1'b1;
        res_r <= pse_pkg::Q_MIN;
      end else begin
        sat_r <= 1'b0;
        res_r <= neg_r ? (~dvd_r[31:0] + 32'd1) : dvd_r[31:0];
      end
    end
  end

  assign out_data = out_r;

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && tok_r.req_type == pse_pkg::REQ_END)
      |=> (cnt_r == '0 && err_r == pse_pkg::ST_OK))
    else $error("end token left stack or error behind");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(pse_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

endmodule

@@ design/postfix_stack_evaluator_core.sv @@
`timescale 1ns / 1ps

// Postfix evaluator over signed Q16.16 tokens: push, operator (+ - * /) and
// end. Each token gives one result carrying the sticky status, the value
// pushed or computed (or the final answer on end), and expr_done on end;
// a req_type of 3 is taken and dropped with no result. One token is in work
// at a time. Push, end, unknown operator and underflow go from idle to the
// finish state; add and subtract pass through an add/subtract state,
// multiply through multiply and product-fix states, and divide through an
// init state, the divider and a fix state. The divider produces one
// quotient bit per cycle; a divide by zero skips it. The result register
// lets the next token transfer in while a result waits on out_ready.

module postfix_stack_evaluator_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pse_pkg::out_t out_data
);

  pse_pkg::cmd_t  cmd;
  pse_pkg::stat_t stat;

  pse_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_op_code  (in_data.op_code),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  pse_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

@@ verif/postfix_stack_evaluator_core_tb.sv @@
`timescale 1ns / 1ps

module postfix_stack_evaluator_core_tb;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [2:0] OP_BAD   = 3'd7;

  typedef struct {
    pse_pkg::in_t  tok;
    bit            lit;
    pse_pkg::out_t want;
  } plan_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  pse_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  pse_pkg::out_t out_data;

  pse_pkg::out_t results_due[$];
  int            mismatches = 0;
  int            tokens_fed = 0;
  int            ready_hold = 0;
  logic          steady = 1'b0;
  plan_row_t     plan [26];

  // evaluator shadow state
  logic signed [31:0] opnd_stk [pse_pkg::STACK_DEPTH];
  int unsigned        opnd_cnt = 0;
  logic [2:0]         held_err = pse_pkg::ST_OK;

  postfix_stack_evaluator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flag_err(logic [2:0] code);
    if (held_err == pse_pkg::ST_OK) held_err = code;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(pse_pkg::Q_MAX)) begin
      flag_err(pse_pkg::ST_SATURATED);
      return pse_pkg::Q_MAX;
    end
    if (v < longint'(pse_pkg::Q_MIN)) begin
      flag_err(pse_pkg::ST_SATURATED);
      return pse_pkg::Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] combine(logic [2:0] op, logic signed [31:0] second,
                                                 logic signed [31:0] first);
    longint a;
    longint b;
    a = second;
    b = first;
    case (op)
      pse_pkg::OP_ADD: return sat32(a + b);
      pse_pkg::OP_SUB: return sat32(a - b);
      pse_pkg::OP_MUL: return sat32((a * b) >>> pse_pkg::FRAC_BITS);
      default: begin
        if (b == 0) begin
          flag_err(pse_pkg::ST_SATURATED);
          return (a < 0) ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
        end
        return sat32((a <<< pse_pkg::FRAC_BITS) / b);
      end
    endcase
  endfunction

  task automatic eval_token(input pse_pkg::in_t tok, output pse_pkg::out_t res,
                            output bit gives);
    logic signed [31:0] ans;
    bit                 closes;
    ans    = '0;
    closes = 1'b0;
    gives  = 1'b1;
    case (tok.req_type)
      pse_pkg::REQ_PUSH: begin
        if (opnd_cnt >= pse_pkg::STACK_DEPTH) begin
          flag_err(pse_pkg::ST_OVERFLOW);
        end else begin
          opnd_stk[opnd_cnt] = tok.value;
          opnd_cnt++;
        end
        ans = tok.value;
      end
      pse_pkg::REQ_OP: begin
        if (tok.op_code > pse_pkg::OP_DIV) begin
          flag_err(pse_pkg::ST_UNKNOWN_OP);
        end else if (opnd_cnt < 2) begin
          flag_err(pse_pkg::ST_UNDERFLOW);
        end else begin
          ans = combine(tok.op_code, opnd_stk[opnd_cnt - 2], opnd_stk[opnd_cnt - 1]);
          opnd_cnt--;
          opnd_stk[opnd_cnt - 1] = ans;
        end
      end
      pse_pkg::REQ_END: begin
        if (opnd_cnt == 0) begin
          flag_err(pse_pkg::ST_UNDERFLOW);
        end else begin
          ans = opnd_stk[opnd_cnt - 1];
          if (opnd_cnt > 1) flag_err(pse_pkg::ST_LEFTOVER);
        end
        closes = 1'b1;
      end
      default: gives = 1'b0;
    endcase
    res = '{status: held_err, answer: ans, expr_done: closes};
    if (closes) begin
      opnd_cnt = 0;
      held_err = pse_pkg::ST_OK;
    end
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      4: return '0;
      5: begin
        case ($urandom_range(3))
          0: return pse_pkg::Q_MAX;
          1: return pse_pkg::Q_MIN;
          2: return 32'sh0001_0000;
          default: return 32'shFFFF_0000;
        endcase
      end
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic sender_gap();
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic issue(input pse_pkg::in_t tok, input bit lit, input pse_pkg::out_t want);
    pse_pkg::out_t pred;
    bit            gives;
    sender_gap();
    in_valid <= 1'b1;
    in_data  <= tok;
    do @(posedge clk); while (!in_ready);
    eval_token(tok, pred, gives);
    if (gives) begin
      results_due.push_back(lit ? want : pred);
      tokens_fed++;
    end
  endtask

  task automatic run_expression(input int unsigned n_opnd, input bit push_first);
    int unsigned d;
    int unsigned pushed;
    logic [2:0]  op;
    d      = 0;
    pushed = 0;
    while (pushed < n_opnd || d > 1) begin
      if (d < 2 || (pushed < n_opnd && (push_first || $urandom_range(1) == 1))) begin
        issue('{pse_pkg::REQ_PUSH, rand_q(), 3'($urandom_range(7))}, 1'b0, '0);
        d++;
        pushed++;
      end else begin
        if ($urandom_range(19) == 0) op = 3'($urandom_range(pse_pkg::OP_DIV + 1, OP_BAD));
        else op = 3'($urandom_range(pse_pkg::OP_DIV));
        issue('{pse_pkg::REQ_OP, $signed(32'($urandom)), op}, 1'b0, '0);
        d--;
      end
    end
    issue('{pse_pkg::REQ_END, $signed(32'($urandom)), 3'($urandom_range(7))}, 1'b0, '0);
  endtask

  task automatic drain_results();
    while (results_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin : result_check
    pse_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected transfer: status %0d answer %h", out_data.status,
               out_data.answer);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.answer !== want.answer) begin
          $error("answer: expected %h, got %h", want.answer, out_data.answer);
          mismatches++;
        end
        if (out_data.expr_done !== want.expr_done) begin
          $error("expr_done: expected %0d, got %0d", want.expr_done, out_data.expr_done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit pressed;
    bit paused;
    pressed = 1'b0;
    paused  = 1'b0;
    plan = '{
      '{'{pse_pkg::REQ_END,  32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_UNDERFLOW,  32'sd0,         1'b1}},
      '{'{pse_pkg::REQ_PUSH, pse_pkg::Q_MAX, pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_OK,         pse_pkg::Q_MAX, 1'b0}},
      '{'{pse_pkg::REQ_PUSH, pse_pkg::Q_MAX, OP_BAD}, 1'b1,
        '{pse_pkg::ST_OK,         pse_pkg::Q_MAX, 1'b0}},
      '{'{pse_pkg::REQ_OP,   32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_SATURATED,  pse_pkg::Q_MAX, 1'b0}},
      '{'{pse_pkg::REQ_END,  32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_SATURATED,  pse_pkg::Q_MAX, 1'b1}},
      '{'{pse_pkg::REQ_PUSH, pse_pkg::Q_MIN, pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_OK,         pse_pkg::Q_MIN, 1'b0}},
      '{'{pse_pkg::REQ_PUSH, 32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_OK,         32'sd0,         1'b0}},
      '{'{pse_pkg::REQ_OP,   32'sd0,         pse_pkg::OP_DIV}, 1'b1,
        '{pse_pkg::ST_SATURATED,  pse_pkg::Q_MIN, 1'b0}},
      '{'{pse_pkg::REQ_END,  32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_SATURATED,  pse_pkg::Q_MIN, 1'b1}},
      '{'{pse_pkg::REQ_OP,   32'sd0,         OP_BAD}, 1'b1,
        '{pse_pkg::ST_UNKNOWN_OP, 32'sd0,         1'b0}},
      '{'{pse_pkg::REQ_OP,   32'sd0,         pse_pkg::OP_MUL}, 1'b1,
        '{pse_pkg::ST_UNKNOWN_OP, 32'sd0,         1'b0}},
      '{'{pse_pkg::REQ_END,  32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_UNKNOWN_OP, 32'sd0,         1'b1}},
      '{'{REQ_NONE,          32'sh1234_5678, OP_BAD}, 1'b0, '0},
      '{'{pse_pkg::REQ_PUSH, pse_pkg::Q_MIN, pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_OK,         pse_pkg::Q_MIN, 1'b0}},
      '{'{pse_pkg::REQ_PUSH, pse_pkg::Q_MIN, pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_OK,         pse_pkg::Q_MIN, 1'b0}},
      '{'{pse_pkg::REQ_OP,   32'sd0,         pse_pkg::OP_MUL}, 1'b1,
        '{pse_pkg::ST_SATURATED,  pse_pkg::Q_MAX, 1'b0}},
      '{'{pse_pkg::REQ_END,  32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_SATURATED,  pse_pkg::Q_MAX, 1'b1}},
      '{'{pse_pkg::REQ_PUSH, 32'sh0001_8000, pse_pkg::OP_ADD}, 1'b0, '0},
      '{'{pse_pkg::REQ_PUSH, 32'shFFFD_C000, pse_pkg::OP_ADD}, 1'b0, '0},
      '{'{pse_pkg::REQ_OP,   32'sd0,         pse_pkg::OP_MUL}, 1'b0, '0},
      '{'{pse_pkg::REQ_PUSH, 32'shFFFF_8000, pse_pkg::OP_ADD}, 1'b0, '0},
      '{'{pse_pkg::REQ_OP,   32'sd0,         pse_pkg::OP_DIV}, 1'b0, '0},
      '{'{pse_pkg::REQ_PUSH, 32'shFFFF_8000, pse_pkg::OP_ADD}, 1'b0, '0},
      '{'{pse_pkg::REQ_OP,   32'sd0,         pse_pkg::OP_SUB}, 1'b0, '0},
      '{'{pse_pkg::REQ_PUSH, 32'sh0005_0000, pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_OK,         32'sh0005_0000, 1'b0}},
      '{'{pse_pkg::REQ_END,  32'sd0,         pse_pkg::OP_ADD}, 1'b1,
        '{pse_pkg::ST_LEFTOVER,   32'sh0005_0000, 1'b1}}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) issue(plan[i].tok, plan[i].lit, plan[i].want);

    tokens_fed = 0;
    while (tokens_fed < 1100) begin
      if (!pressed && tokens_fed >= 300) begin
        ready_hold <= 400;
        pressed = 1'b1;
      end
      steady <= (tokens_fed >= 600 && tokens_fed < 800);
      if (!paused && tokens_fed >= 900) begin
        in_valid <= 1'b0;
        drain_results();
        paused = 1'b1;
      end
      case ($urandom_range(19))
        14, 15: run_expression($urandom_range(14, 20), 1'b1);
        16, 17, 18, 19: begin
          repeat ($urandom_range(1, 8))
            issue('{2'($urandom_range(3)), $signed(32'($urandom)), 3'($urandom_range(7))},
                  1'b0, '0);
        end
        default: run_expression($urandom_range(1, 6), 1'b0);
      endcase
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
